@@ hw/rtl/slfc_pkg.sv @@
// Shared types and constants for the switched LED fade controller.
// No dependencies; the output and configuration interfaces and the top level import it.
package slfc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_MS    = 3'd0,
    CFG_TOGGLE_MODE    = 3'd1,
    CFG_FADE_IN_MS     = 3'd2,
    CFG_FADE_OUT_MS    = 3'd3,
    CFG_FRAME_INTERVAL = 3'd4,
    CFG_MAX_BRIGHTNESS = 3'd5,
    CFG_RAINBOW_SPEED  = 3'd6,
    CFG_GAMMA_ENABLE   = 3'd7
  } cfg_idx_t;

  // Lamp state as reported on the result word.
  typedef enum logic [1:0] {
    ST_OFF      = 2'd0,
    ST_FADE_IN  = 2'd1,
    ST_ON       = 2'd2,
    ST_FADE_OUT = 2'd3
  } fade_state_t;

  localparam logic [7:0] LEVEL_FULL  = 8'd255;
  localparam logic [7:0] LEVEL_ZERO  = 8'd0;

  // Shared restoring divider: 24-bit dividend, 16-bit divisor.
  localparam int DIV_STEPS = 24;
  localparam int DIV_CNT_W = 5;

endpackage

@@ hw/rtl/slfc_in_if.sv @@
// Input channel of the fade controller: one raw switch sample per word.
// Depends on nothing.
interface slfc_in_if ();
  logic valid;
  logic ready;
  logic switch_closed;

  modport source (output valid, output switch_closed, input ready);
  modport sink   (input valid, input switch_closed, output ready);
endinterface

@@ hw/rtl/slfc_out_if.sv @@
// Result channel of the fade controller: brightness, level, state, hue and strip flags.
// Depends on slfc_pkg for the state type.
interface slfc_out_if import slfc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  brightness;
  logic [7:0]  fade_level;
  fade_state_t mode_state;
  logic [7:0]  base_hue;
  logic        frame_refresh;
  logic        strip_power;

  modport source (output valid, output brightness, output fade_level, output mode_state,
                  output base_hue, output frame_refresh, output strip_power, input ready);
  modport sink   (input valid, input brightness, input fade_level, input mode_state,
                  input base_hue, input frame_refresh, input strip_power, output ready);
endinterface

@@ hw/rtl/slfc_cfg_if.sv @@
// Configuration write channel of the fade controller: register index and data.
// Depends on slfc_pkg for the index type and data width.
interface slfc_cfg_if import slfc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/switched_led_fade_controller.sv @@
// Top level of the switched LED fade controller: debounce, fade sequencer, output register.
// Depends on slfc_pkg and the channel interfaces slfc_in_if, slfc_out_if, slfc_cfg_if.
//
//   channel   direction  word
//   sw_in     sink       switch_closed, one sample per millisecond tick
//   led_out   source     brightness, fade_level, mode_state, base_hue, frame_refresh, strip_power
//   cfg       sink       index, data; ready whenever reset is low
//
// A tick runs through the sequencer from acceptance to its result, using the one shared
// 24-step restoring divider, run once when a fade starts and once for a fade frame, and
// the 16x9 multiplier it shares the sequencer with, one product per sequencer state.
// Reset is synchronous and restores the register defaults and the off state.
// A result waits in the output register; only the last step stalls while it is not taken.
module switched_led_fade_controller import slfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  slfc_in_if.sink    sw_in,
  slfc_out_if.source led_out,
  slfc_cfg_if.sink   cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_DUR_MUL, S_DUR_DIV, S_FRAME, S_P_MUL, S_P_DIV,
    S_SQ, S_CU, S_EASE, S_INTERP, S_GAMMA, S_DONE
  } seq_t;

  // Configuration registers.
  logic [15:0] debounce_ms;
  logic        toggle_mode;
  logic [15:0] rise_span;
  logic [15:0] fall_span;
  logic [9:0]  frame_interval_ms;
  logic [7:0]  max_brightness;
  logic [15:0] rainbow_speed;
  logic        gamma_enable;

  // Controller state.
  seq_t        seq;
  logic        stable_contact;
  logic        last_sample;
  logic [15:0] settle_count;
  logic        prev_stable;
  logic        toggle_desire;
  fade_state_t fade_state;
  logic [7:0]  level;
  logic [7:0]  start_level;
  logic [7:0]  target_level;
  logic [15:0] elapsed_ms;
  logic [15:0] fade_duration;
  logic [9:0]  frame_count;
  logic [15:0] hue_accum;
  logic        power_on;
  logic        frame_due;
  logic        refresh;

  // Work registers of the shared units.
  logic [7:0]           frac;
  logic [7:0]           sq;
  logic [7:0]           cu;
  logic [23:0]          div_quo;
  logic [15:0]          div_rem;
  logic [15:0]          div_dvs;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Output register.
  logic        out_valid;
  logic [7:0]  out_bright;
  logic [7:0]  out_level;
  fade_state_t out_state;
  logic [7:0]  out_hue;
  logic        out_refresh;
  logic        out_power;

  // Tick front end.
  logic        sample;
  logic [15:0] settle_next;
  logic        stable_next;
  logic        toggle_next;
  logic        desire;
  logic [9:0]  frame_inc;
  logic        due_next;

  // Shared datapath.
  logic [15:0] mul_a;
  logic [8:0]  mul_b;
  logic [24:0] mul_p;
  logic [7:0]  scaled;
  logic [7:0]  diff;
  logic [16:0] div_trial;
  logic        div_bit;
  logic [15:0] div_rem_next;
  logic [23:0] div_quo_next;
  logic [9:0]  ease_raw;
  logic [15:0] full_ms;
  logic        fade_done;
  logic        accept;
  logic        out_load;

  assign accept   = sw_in.valid && sw_in.ready;
  assign out_load = (seq == S_DONE) && (!out_valid || led_out.ready);
  assign sw_in.ready = (seq == S_IDLE) && !rst;
  assign cfg.ready   = !rst;

  assign led_out.valid         = out_valid;
  assign led_out.brightness    = out_bright;
  assign led_out.fade_level    = out_level;
  assign led_out.mode_state    = out_state;
  assign led_out.base_hue      = out_hue;
  assign led_out.frame_refresh = out_refresh;
  assign led_out.strip_power   = out_power;

  // Debounce, desire and frame timing for the word being accepted.
  always_comb begin
    sample      = sw_in.switch_closed;
    settle_next = (settle_count != 16'hFFFF) ? settle_count + 16'd1 : settle_count;
    stable_next = stable_contact;
    if (sample != last_sample) begin
      settle_next = '0;
    end else if (settle_next >= debounce_ms) begin
      stable_next = sample;
    end
    toggle_next = toggle_desire ^ (stable_next && !prev_stable);
    desire      = toggle_mode ? toggle_next : stable_next;
    frame_inc   = (frame_count != 10'h3FF) ? frame_count + 10'd1 : frame_count;
    due_next    = (frame_inc >= frame_interval_ms);
  end

  assign diff      = (target_level > start_level) ? target_level - start_level
                                                  : start_level - target_level;
  assign full_ms   = (fade_state == ST_FADE_IN) ? rise_span : fall_span;
  assign fade_done = (fade_duration == 16'd0) || (elapsed_ms >= fade_duration);

  // Shared multiplier; the scaled form is (a * (b + 1)) >> 8 with an 8-bit a.
  always_comb begin
    unique case (seq)
      S_DUR_MUL: begin mul_a = full_ms;          mul_b = {1'b0, diff};           end
      S_P_MUL:   begin mul_a = elapsed_ms;       mul_b = {1'b0, LEVEL_FULL};     end
      S_SQ:      begin mul_a = {8'd0, frac};     mul_b = {1'b0, frac} + 9'd1;    end
      S_CU:      begin mul_a = {8'd0, sq};       mul_b = {1'b0, frac} + 9'd1;    end
      S_INTERP:  begin mul_a = {8'd0, diff};     mul_b = {1'b0, frac} + 9'd1;    end
      S_GAMMA:   begin mul_a = {8'd0, level};    mul_b = {1'b0, level} + 9'd1;   end
      S_DONE:    begin mul_a = {8'd0, max_brightness}; mul_b = {1'b0, sq} + 9'd1; end
      default:   begin mul_a = '0;               mul_b = '0;                     end
    endcase
  end
  assign mul_p  = {9'd0, mul_a} * {16'd0, mul_b};
  assign scaled = mul_p[15:8];

  // One restoring division step per cycle.
  always_comb begin
    div_trial    = {div_rem, div_quo[23]};
    div_bit      = (div_trial >= {1'b0, div_dvs});
    div_rem_next = div_bit ? 16'(div_trial - {1'b0, div_dvs}) : div_trial[15:0];
    div_quo_next = {div_quo[22:0], div_bit};
  end

  // Cubic ease: 3*sq - 2*cu, saturated when bit 8 is set.
  assign ease_raw = ({2'b00, sq} + {1'b0, sq, 1'b0}) - {1'b0, cu, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms       <= 16'd50;
      toggle_mode       <= 1'b0;
      rise_span         <= 16'd3000;
      fall_span         <= 16'd3000;
      frame_interval_ms <= 10'd16;
      max_brightness    <= 8'd255;
      rainbow_speed     <= 16'd64;
      gamma_enable      <= 1'b1;
      seq               <= S_IDLE;
      stable_contact    <= 1'b0;
      last_sample       <= 1'b0;
      settle_count      <= '0;
      prev_stable       <= 1'b0;
      toggle_desire     <= 1'b0;
      fade_state        <= ST_OFF;
      level             <= '0;
      start_level       <= '0;
      target_level      <= '0;
      elapsed_ms        <= '0;
      fade_duration     <= '0;
      frame_count       <= '0;
      hue_accum         <= '0;
      power_on          <= 1'b0;
      frame_due         <= 1'b0;
      refresh           <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_DEBOUNCE_MS:    debounce_ms       <= cfg.data;
          CFG_TOGGLE_MODE:    toggle_mode       <= cfg.data[0];
          CFG_FADE_IN_MS:     rise_span         <= cfg.data;
          CFG_FADE_OUT_MS:    fall_span         <= cfg.data;
          CFG_FRAME_INTERVAL: frame_interval_ms <= cfg.data[9:0];
          CFG_MAX_BRIGHTNESS: max_brightness    <= cfg.data[7:0];
          CFG_RAINBOW_SPEED:  rainbow_speed     <= cfg.data;
          CFG_GAMMA_ENABLE:   gamma_enable      <= cfg.data[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (led_out.ready) begin
        out_valid <= 1'b0;
      end

      unique case (seq)
        S_IDLE: begin
          if (accept) begin
            last_sample    <= sample;
            settle_count   <= settle_next;
            stable_contact <= stable_next;
            prev_stable    <= stable_next;
            toggle_desire  <= toggle_next;
            frame_due      <= due_next;
            frame_count    <= due_next ? 10'd0 : frame_inc;
            refresh        <= 1'b0;
            seq            <= S_FRAME;
            if (desire && (fade_state == ST_OFF || fade_state == ST_FADE_OUT)) begin
              if (fade_state == ST_OFF) begin
                power_on <= 1'b1;
              end
              start_level  <= level;
              target_level <= LEVEL_FULL;
              elapsed_ms   <= '0;
              fade_state   <= ST_FADE_IN;
              seq          <= S_DUR_MUL;
            end else if (!desire && (fade_state == ST_ON || fade_state == ST_FADE_IN)) begin
              start_level  <= level;
              target_level <= LEVEL_ZERO;
              elapsed_ms   <= '0;
              fade_state   <= ST_FADE_OUT;
              seq          <= S_DUR_MUL;
            end
          end
        end
        S_DUR_MUL: begin
          // Duration scaled by distance: full_ms * distance / 255.
          div_quo <= mul_p[23:0];
          div_rem <= '0;
          div_dvs <= {8'd0, LEVEL_FULL};
          div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
          seq     <= S_DUR_DIV;
        end
        S_DUR_DIV: begin
          div_quo <= div_quo_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == '0) begin
            fade_duration <= div_quo_next[15:0];
            seq           <= S_FRAME;
          end
        end
        S_FRAME: begin
          seq <= S_GAMMA;
          if (frame_due && fade_state != ST_OFF) begin
            refresh <= 1'b1;
            if (fade_state == ST_FADE_OUT && fade_done) begin
              // Fade out ends: black frame, supply off, hue holds.
              level      <= target_level;
              fade_state <= ST_OFF;
              power_on   <= 1'b0;
            end else begin
              hue_accum <= hue_accum + rainbow_speed;
              if (fade_state == ST_FADE_IN && fade_done) begin
                level      <= target_level;
                fade_state <= ST_ON;
              end else if (fade_state != ST_ON) begin
                seq <= S_P_MUL;
              end
            end
          end
        end
        S_P_MUL: begin
          // Progress fraction: elapsed * 255 / duration, always below 255 here.
          div_quo <= mul_p[23:0];
          div_rem <= '0;
          div_dvs <= fade_duration;
          div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
          seq     <= S_P_DIV;
        end
        S_P_DIV: begin
          div_quo <= div_quo_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == '0) begin
            frac <= div_quo_next[7:0];
            seq  <= S_SQ;
          end
        end
        S_SQ: begin
          sq  <= scaled;
          seq <= S_CU;
        end
        S_CU: begin
          cu  <= scaled;
          seq <= S_EASE;
        end
        S_EASE: begin
          frac <= ease_raw[8] ? LEVEL_FULL : ease_raw[7:0];
          seq  <= S_INTERP;
        end
        S_INTERP: begin
          level <= (target_level > start_level) ? start_level + scaled : start_level - scaled;
          seq   <= S_GAMMA;
        end
        S_GAMMA: begin
          if (elapsed_ms != 16'hFFFF) begin
            elapsed_ms <= elapsed_ms + 16'd1;
          end
          // sq now carries the brightness term: the gamma-corrected level, or the level itself when gamma is off.
          sq  <= gamma_enable ? scaled : level;
          seq <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_bright  <= (fade_state == ST_OFF) ? 8'd0 : scaled;
            out_level   <= level;
            out_state   <= fade_state;
            out_hue     <= hue_accum[15:8];
            out_refresh <= refresh;
            out_power   <= power_on;
            seq         <= S_IDLE;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

endmodule
